/* design/max_priority_queue_top_defines.svh */
// Assertion macros shared by the max priority queue RTL.
`ifndef MAX_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define MPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MPQ_ASSERT(label, clk, rst_n, prop, msg)
`define MPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/mpq_pkg.sv */
// Shared constants, codes and types of the max priority queue.
package mpq_pkg;

    localparam int CAPACITY    = 64;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int CNT_FIELD_W = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_SCAN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic accept;
        logic shift_en;
        logic scan_start;
        logic scan_en;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_empty;
        logic shift_done;
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage

/* design/mpq_ifs.sv */
// Handshake channel interfaces for command items and result items.
interface mpq_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic signed [mpq_pkg::DATA_W-1:0]    entry_name;
    logic signed [mpq_pkg::DATA_W-1:0]    entry_priority;

    modport source (output valid, cmd, entry_name, entry_priority, input ready);
    modport sink   (input valid, cmd, entry_name, entry_priority, output ready);
endinterface

interface mpq_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mpq_pkg::DATA_W-1:0]    head_name;
    logic                                 is_empty;
    logic [mpq_pkg::CNT_FIELD_W-1:0]      entry_count;
    logic [1:0]                           error_code;

    modport source (output valid, head_name, is_empty, entry_count, error_code,
                    input ready);
    modport sink   (input valid, head_name, is_empty, entry_count, error_code,
                    output ready);
endinterface

/* design/mpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/mpq_ctrl.sv */
// Controller state machine: sequences insert, delete shift and rescan, and result hand-off.
module mpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_cmd,
    output logic              o_in_ready,
    input  mpq_pkg::t_dp_stat i_stat,
    output mpq_pkg::t_dp_cmd  o_cmd
);

    mpq_pkg::t_state r_state;
    mpq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            mpq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_cmd == mpq_pkg::CMD_DELETE && !i_stat.is_empty) begin
                        n_state = mpq_pkg::S_SHIFT;
                    end else begin
                        n_state = mpq_pkg::S_RESULT;
                    end
                end
            end
            mpq_pkg::S_SHIFT: begin
                o_cmd.shift_en = 1'b1;
                if (i_stat.shift_done) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = mpq_pkg::S_SCAN;
                end
            end
            mpq_pkg::S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = mpq_pkg::S_RESULT;
                end
            end
            mpq_pkg::S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = mpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* design/mpq_dp.sv */
// Datapath: entry stores, fill count, head tracking, shift and scan walker, result register.
`include "max_priority_queue_top_defines.svh"
module mpq_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mpq_pkg::t_dp_cmd                      i_cmd,
    output mpq_pkg::t_dp_stat                     o_stat,
    input  logic                                  i_in_cmd,
    input  logic signed [mpq_pkg::DATA_W-1:0]     i_in_name,
    input  logic signed [mpq_pkg::DATA_W-1:0]     i_in_prio,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic signed [mpq_pkg::DATA_W-1:0]     o_out_head_name,
    output logic                                  o_out_is_empty,
    output logic [mpq_pkg::CNT_FIELD_W-1:0]       o_out_count,
    output mpq_pkg::t_err                         o_out_err
);

    logic [mpq_pkg::CNT_W-1:0]             r_count;
    logic [mpq_pkg::CNT_W-1:0]             r_addr;
    logic                                  r_pend;
    logic [mpq_pkg::IDX_W-1:0]             r_tag;
    logic                                  r_have;
    logic [mpq_pkg::IDX_W-1:0]             r_head_pos;
    logic signed [mpq_pkg::DATA_W-1:0]     r_head_name;
    logic signed [mpq_pkg::DATA_W-1:0]     r_head_prio;
    mpq_pkg::t_err                         r_err;
    logic                                  r_out_valid;
    logic signed [mpq_pkg::DATA_W-1:0]     r_out_name;
    logic                                  r_out_empty;
    logic [mpq_pkg::CNT_FIELD_W-1:0]       r_out_count;
    mpq_pkg::t_err                         r_out_err;

    logic                                  is_empty;
    logic                                  is_full;
    logic                                  do_ins;
    logic                                  do_del;
    logic                                  walk;
    logic                                  issue;
    logic                                  shift_wr;
    logic                                  scan_take;
    logic                                  ram_we;
    logic [mpq_pkg::IDX_W-1:0]             ram_waddr;
    logic [mpq_pkg::DATA_W-1:0]            wr_name;
    logic [mpq_pkg::DATA_W-1:0]            wr_prio;
    logic [mpq_pkg::DATA_W-1:0]            rd_name;
    logic [mpq_pkg::DATA_W-1:0]            rd_prio;

    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count == mpq_pkg::CNT_W'(mpq_pkg::CAPACITY));
    assign do_ins    = i_cmd.accept && (i_in_cmd == mpq_pkg::CMD_INSERT) && !is_full;
    assign do_del    = i_cmd.accept && (i_in_cmd == mpq_pkg::CMD_DELETE) && !is_empty;
    assign walk      = i_cmd.shift_en || i_cmd.scan_en;
    assign issue     = walk && (r_addr < r_count);
    assign shift_wr  = i_cmd.shift_en && r_pend;
    // The first entry seen always wins; later ones only on a strictly larger priority,
    // so the earliest of equal priorities stays the head.
    assign scan_take = i_cmd.scan_en && r_pend &&
                       (!r_have || ($signed(rd_prio) > r_head_prio));

    assign ram_we    = do_ins || shift_wr;
    assign ram_waddr = do_ins ? r_count[mpq_pkg::IDX_W-1:0] : (r_tag - mpq_pkg::IDX_W'(1));
    assign wr_name   = do_ins ? i_in_name : rd_name;
    assign wr_prio   = do_ins ? i_in_prio : rd_prio;

    mpq_ram #(
        .WIDTH (mpq_pkg::DATA_W),
        .DEPTH (mpq_pkg::CAPACITY)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_name),
        .i_re    (issue),
        .i_raddr (r_addr[mpq_pkg::IDX_W-1:0]),
        .o_rdata (rd_name)
    );

    mpq_ram #(
        .WIDTH (mpq_pkg::DATA_W),
        .DEPTH (mpq_pkg::CAPACITY)
    ) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_prio),
        .i_re    (issue),
        .i_raddr (r_addr[mpq_pkg::IDX_W-1:0]),
        .o_rdata (rd_prio)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_have      <= 1'b0;
            r_err       <= mpq_pkg::ERR_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (i_in_cmd == mpq_pkg::CMD_INSERT) begin
                    r_err <= is_full ? mpq_pkg::ERR_FULL : mpq_pkg::ERR_OK;
                end else begin
                    r_err <= is_empty ? mpq_pkg::ERR_EMPTY : mpq_pkg::ERR_OK;
                end
            end
            if (do_ins) begin
                r_count <= r_count + mpq_pkg::CNT_W'(1);
                if (is_empty || (i_in_prio > r_head_prio)) begin
                    r_head_pos  <= r_count[mpq_pkg::IDX_W-1:0];
                    r_head_name <= i_in_name;
                    r_head_prio <= i_in_prio;
                end
            end
            // The walk starts behind the removed head and moves every later entry down.
            if (do_del) begin
                r_addr <= mpq_pkg::CNT_W'(r_head_pos) + mpq_pkg::CNT_W'(1);
                r_pend <= 1'b0;
            end
            if (walk) begin
                r_pend <= issue;
                r_tag  <= r_addr[mpq_pkg::IDX_W-1:0];
                if (issue) begin
                    r_addr <= r_addr + mpq_pkg::CNT_W'(1);
                end
            end
            if (scan_take) begin
                r_head_pos  <= r_tag;
                r_head_name <= $signed(rd_name);
                r_head_prio <= $signed(rd_prio);
                r_have      <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_count <= r_count - mpq_pkg::CNT_W'(1);
                r_addr  <= '0;
                r_pend  <= 1'b0;
                r_have  <= 1'b0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_name  <= is_empty ? '0 : r_head_name;
            r_out_empty <= is_empty;
            r_out_count <= mpq_pkg::CNT_FIELD_W'(r_count);
            r_out_err   <= r_err;
        end
    end

    assign o_stat.is_empty   = is_empty;
    assign o_stat.shift_done = !issue && !r_pend;
    assign o_stat.scan_done  = !issue && !r_pend;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_out_head_name = r_out_name;
    assign o_out_is_empty  = r_out_empty;
    assign o_out_count     = r_out_count;
    assign o_out_err       = r_out_err;

    `MPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= mpq_pkg::CNT_W'(mpq_pkg::CAPACITY), "fill count above capacity")
    `MPQ_ASSERT_IMP(a_ins_room, i_clk, i_rst_n, do_ins, !is_full, "insert written into a full store")
    `MPQ_ASSERT_IMP(a_shift_addr, i_clk, i_rst_n, shift_wr, mpq_pkg::CNT_W'(r_tag) < r_count, "shift write beyond the stored entries")
    `MPQ_ASSERT_IMP(a_head_pos, i_clk, i_rst_n, i_cmd.load_out && !is_empty, mpq_pkg::CNT_W'(r_head_pos) < r_count, "head position outside the stored entries")

endmodule

/* design/max_priority_queue_top.sv */
// Max priority queue over an unsorted array: top level joining controller and datapath.
//
// Usage: command items arrive on i_cmd (valid/ready); cmd selects insert or delete of the
// highest-priority entry. Every accepted command gives exactly one result item on o_res
// with the head name after the command, an empty flag, the entry count and an error code
// (insert into a full queue or delete from an empty queue is refused and reported).
// Items are handled one at a time. An insert or a refused command goes from the accept
// cycle to a state that loads the result register as soon as that register is free. A
// delete walks the entry memories twice, one memory read per cycle: one pass moves the
// later entries down, a second pass rescans the survivors for the new head.
// The next command is accepted as soon as the previous result sits in the output
// register, even while the receiver has not yet taken it.
// If the receiver stalls, the result holds in the output register and the following
// command's result waits in the controller until the register frees.
// Synchronous reset empties the queue at once; the entry memories need no clearing.
module max_priority_queue_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpq_cmd_if.sink   i_cmd,
    mpq_res_if.source o_res
);

    mpq_pkg::t_dp_cmd  dp_cmd;
    mpq_pkg::t_dp_stat dp_stat;
    logic              in_ready;
    mpq_pkg::t_err     out_err;

    mpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_in_cmd   (i_cmd.cmd),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    mpq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_in_cmd        (i_cmd.cmd),
        .i_in_name       (i_cmd.entry_name),
        .i_in_prio       (i_cmd.entry_priority),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_out_head_name (o_res.head_name),
        .o_out_is_empty  (o_res.is_empty),
        .o_out_count     (o_res.entry_count),
        .o_out_err       (out_err)
    );

    assign i_cmd.ready      = in_ready;
    assign o_res.error_code = out_err;

endmodule
